// ----- src/mcct_pkg.sv -----
// Shared types and codes for the multi-channel countdown timer.
`default_nettype none

package mcct_pkg;

  localparam logic [2:0] REQ_TIME     = 3'd0;
  localparam logic [2:0] REQ_ONE_SHOT = 3'd1;
  localparam logic [2:0] REQ_PERIODIC = 3'd2;
  localparam logic [2:0] REQ_STOP     = 3'd3;
  localparam logic [2:0] REQ_QUERY    = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  channel;
    logic [15:0] load_value;
    logic        notify_enable;
    logic [7:0]  elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  fire_mask;
    logic [15:0] remaining;
    logic        ticked;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CMP,
    S_TICK,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/multi_channel_countdown_timer.sv -----
// Top level of the multi-channel countdown timer bank.
// Usage: present a request word on in_word and raise start while busy is low;
// the word is taken at that clock edge and busy rises until the result is out.
// Each request yields exactly one result word on out_word, valid for the single
// cycle in which out_valid is high; the receiver cannot hold it off.
// Path from the accepting edge to the out_valid cycle, by request:
//   set, stop, query, unused codes: EXEC, then DONE.
//   time update without a tick: EXEC, CMP, then DONE.
//   time update with a tick: EXEC, CMP, TICK for every channel, then DONE.
// The tick walks the channels one per cycle through a single shared
// decrement-and-compare unit.
// cfg_data writes tick_period whenever cfg_valid is high (cfg_ready is always
// high); write it only while busy is low and no result is pending.
// Synchronous reset clears all counters, reload values, notify flags and the
// millisecond accumulator, and sets tick_period to 1.
`default_nettype none

module multi_channel_countdown_timer #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mcct_pkg::in_word_t in_word,
  output logic                    out_valid,
  output mcct_pkg::out_word_t     out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  mcct_pkg::state_t state_r, state_nxt;
  mcct_pkg::in_word_t req_r;

  logic [COUNT_BITS-1:0] count_r  [CHANNELS];
  logic [COUNT_BITS-1:0] reload_r [CHANNELS];
  logic                  notify_r [CHANNELS];

  logic [31:0]     acc_r, acc_nxt;
  logic [15:0]     period_r;
  logic [CH_W-1:0] idx_r, idx_nxt;
  logic [7:0]      fire_r, fire_nxt;
  logic [15:0]     rem_r, rem_nxt;
  logic            ticked_r, ticked_nxt;

  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_count;
  logic [COUNT_BITS-1:0] wr_reload;
  logic                  wr_notify;
  logic [CH_W-1:0]       sel_idx;
  logic [CH_W-1:0]       chan_idx;
  logic                  chan_ok;
  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] rd_reload;
  logic                  rd_notify;
  logic [COUNT_BITS-1:0] dec_count;
  logic [COUNT_BITS-1:0] load_cnt;
  logic [32:0]           acc_sum;

  assign busy      = (state_r != mcct_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == mcct_pkg::S_DONE);
  assign out_word  = '{fire_mask: fire_r, remaining: rem_r, ticked: ticked_r};

  assign chan_idx  = CH_W'(req_r.channel);
  assign chan_ok   = (5'(req_r.channel) < 5'(CHANNELS));
  assign sel_idx   = (state_r == mcct_pkg::S_TICK) ? idx_r : chan_idx;
  assign rd_count  = count_r[sel_idx];
  assign rd_reload = reload_r[sel_idx];
  assign rd_notify = notify_r[sel_idx];
  assign dec_count = rd_count - COUNT_BITS'(1);
  assign load_cnt  = COUNT_BITS'(req_r.load_value);
  assign acc_sum   = {1'b0, acc_r} + 33'(req_r.elapsed_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mcct_pkg::S_IDLE;
      acc_r    <= '0;
      period_r <= 16'd1;
      idx_r    <= '0;
      fire_r   <= '0;
      rem_r    <= '0;
      ticked_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        count_r[i]  <= '0;
        reload_r[i] <= '0;
        notify_r[i] <= 1'b0;
      end
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      idx_r    <= idx_nxt;
      fire_r   <= fire_nxt;
      rem_r    <= rem_nxt;
      ticked_r <= ticked_nxt;
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_data;
      end
      if (wr_en) begin
        count_r[sel_idx]  <= wr_count;
        reload_r[sel_idx] <= wr_reload;
        notify_r[sel_idx] <= wr_notify;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_word;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    idx_nxt    = idx_r;
    fire_nxt   = fire_r;
    rem_nxt    = rem_r;
    ticked_nxt = ticked_r;
    wr_en      = 1'b0;
    wr_count   = rd_count;
    wr_reload  = rd_reload;
    wr_notify  = rd_notify;
    unique case (state_r)
      mcct_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = mcct_pkg::S_EXEC;
        end
      end
      mcct_pkg::S_EXEC: begin
        fire_nxt   = '0;
        rem_nxt    = '0;
        ticked_nxt = 1'b0;
        idx_nxt    = '0;
        state_nxt  = mcct_pkg::S_DONE;
        priority if (req_r.req_type == mcct_pkg::REQ_TIME) begin
          acc_nxt   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
          state_nxt = mcct_pkg::S_CMP;
        end else if (req_r.req_type == mcct_pkg::REQ_ONE_SHOT ||
                     req_r.req_type == mcct_pkg::REQ_PERIODIC) begin
          wr_en     = chan_ok;
          wr_count  = load_cnt;
          wr_reload = (req_r.req_type == mcct_pkg::REQ_PERIODIC) ? load_cnt : '0;
          wr_notify = req_r.notify_enable;
        end else if (req_r.req_type == mcct_pkg::REQ_STOP) begin
          wr_en     = chan_ok;
          wr_count  = '0;
          wr_reload = '0;
          wr_notify = 1'b0;
        end else if (req_r.req_type == mcct_pkg::REQ_QUERY) begin
          rem_nxt = chan_ok ? 16'(rd_count) : '0;
        end else begin
          state_nxt = mcct_pkg::S_DONE;
        end
      end
      mcct_pkg::S_CMP: begin
        if (acc_r >= {16'd0, period_r}) begin
          acc_nxt    = acc_r - {16'd0, period_r};
          ticked_nxt = 1'b1;
          state_nxt  = mcct_pkg::S_TICK;
        end else begin
          state_nxt = mcct_pkg::S_DONE;
        end
      end
      mcct_pkg::S_TICK: begin
        if (rd_count != '0) begin
          wr_en = 1'b1;
          if (dec_count == '0) begin
            wr_count = rd_reload;
            if (rd_notify) begin
              fire_nxt = fire_r | (8'd1 << idx_r);
            end
          end else begin
            wr_count = dec_count;
          end
        end
        if (idx_r == LAST_CH) begin
          state_nxt = mcct_pkg::S_DONE;
        end else begin
          idx_nxt = idx_r + CH_W'(1);
        end
      end
      mcct_pkg::S_DONE: begin
        state_nxt = mcct_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mcct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
